@@ src/sti1d_pkg.sv @@
// shared types and constants for the sample table interpolator
package sti1d_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int FRAC_BITS    = 16;
    localparam int POS_BITS     = 32;
    localparam int IDX_BITS     = 10;
    localparam int CNT_BITS     = 11;
    localparam int ADDR_BITS    = 16;
    localparam int W_BITS       = 34;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_BITS     = 16;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COUNT    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAMMA    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MISS_EN  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MISS_VAL = 3'd4;

    localparam logic [1:0] MODE_NEAREST = 2'd0;
    localparam logic [1:0] MODE_LINEAR  = 2'd1;
    localparam logic [1:0] MODE_CUBIC   = 2'd2;
    // unused code, behaves as linear
    localparam logic [1:0] MODE_SPARE   = 2'd3;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_TABLE = 2'd1,
        KIND_MISS  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        WSEL_SAMPLE = 2'd0,
        WSEL_LINEAR = 2'd1,
        WSEL_CUBIC  = 2'd2
    } t_wsel;

    typedef struct packed {
        logic [1:0]                    mode;
        logic [CNT_BITS-1:0]           count;
        logic signed [15:0]            gamma;
        logic                          miss_en;
        logic signed [15:0]            miss_val;
    } t_cfg;

    // routing info carried along the front pipeline
    typedef struct packed {
        t_kind                         kind;
        t_wsel                         wsel;
        logic                          tlast;
        logic                          load_ok;
        logic signed [SAMPLE_BITS-1:0] load_data;
        logic [ADDR_BITS-1:0]          a0;
        logic [ADDR_BITS-1:0]          a1;
        logic [ADDR_BITS-1:0]          a2;
        logic [ADDR_BITS-1:0]          a3;
        logic [FRAC_BITS-1:0]          frac;
    } t_route;

    // one queued work item for the back end
    typedef struct packed {
        t_kind                         kind;
        logic                          tlast;
        logic                          load_ok;
        logic signed [SAMPLE_BITS-1:0] load_data;
        logic [ADDR_BITS-1:0]          a0;
        logic [ADDR_BITS-1:0]          a1;
        logic [ADDR_BITS-1:0]          a2;
        logic [ADDR_BITS-1:0]          a3;
        logic signed [W_BITS-1:0]      w0;
        logic signed [W_BITS-1:0]      w1;
        logic signed [W_BITS-1:0]      w2;
        logic signed [W_BITS-1:0]      w3;
    } t_work;

endpackage

@@ src/sti1d_ram.sv @@
// generic single write port ram with registered read
module sti1d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/sti1d_front.sv @@
// front end: accepts beats, classifies queries, builds the kernel weights
module sti1d_front #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  sti1d_pkg::t_cfg                       i_cfg,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_cmd,
    input  logic [sti1d_pkg::IDX_BITS-1:0]        i_idx,
    input  logic signed [sti1d_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic signed [sti1d_pkg::POS_BITS-1:0] i_pos,
    input  logic                                  i_last,
    input  logic                                  i_q_full,
    output logic                                  o_push,
    output sti1d_pkg::t_work                      o_work
);
    localparam logic [sti1d_pkg::CNT_BITS-1:0] N_CAP =
        (TABLE_DEPTH > 2047) ? 11'd2047 : 11'(TABLE_DEPTH);

    logic adv;
    assign adv     = !i_q_full;
    assign o_ready = adv;

    // classification
    logic [sti1d_pkg::CNT_BITS-1:0] n_eff;
    logic [1:0]                     mode_eff;
    logic signed [17:0]             ip, nn, nm1, tgt, ip_p1, ip_p2;
    logic [16:0]                    idx_x;
    sti1d_pkg::t_route              rt;
    logic [14:0]                    u_c;
    logic [15:0]                    v_c;
    logic signed [15:0]             g_c;

    always_comb begin
        if (i_cfg.count == '0) begin
            n_eff = 11'd1;
        end else if (i_cfg.count > N_CAP) begin
            n_eff = N_CAP;
        end else begin
            n_eff = i_cfg.count;
        end
        mode_eff = (i_cfg.mode == sti1d_pkg::MODE_CUBIC) ? sti1d_pkg::MODE_CUBIC
                 : (i_cfg.mode == sti1d_pkg::MODE_NEAREST) ? sti1d_pkg::MODE_NEAREST
                 : sti1d_pkg::MODE_LINEAR;
        if (mode_eff == sti1d_pkg::MODE_CUBIC && n_eff < 11'd3) begin
            mode_eff = sti1d_pkg::MODE_LINEAR;
        end
        if (n_eff < 11'd2) begin
            mode_eff = sti1d_pkg::MODE_NEAREST;
        end

        ip    = {{2{i_pos[31]}}, i_pos[31:16]};
        nn    = {7'b0, n_eff};
        nm1   = nn - 18'sd1;
        ip_p1 = ip + 18'sd1;
        ip_p2 = ip + 18'sd2;
        tgt   = '0;
        idx_x = {7'b0, i_idx};

        rt.kind      = sti1d_pkg::KIND_TABLE;
        rt.wsel      = sti1d_pkg::WSEL_SAMPLE;
        rt.tlast     = i_last;
        rt.load_ok   = idx_x < 17'(TABLE_DEPTH);
        rt.load_data = i_sample;
        rt.frac      = i_pos[sti1d_pkg::FRAC_BITS-1:0];

        if (!i_cmd) begin
            rt.kind = sti1d_pkg::KIND_LOAD;
            tgt     = $signed({1'b0, idx_x});
        end else if (mode_eff == sti1d_pkg::MODE_NEAREST) begin
            if (i_pos[31]) tgt = '0;
            else if (ip < nm1) tgt = ip;
            else tgt = nm1;
        end else if (i_pos[31]) begin
            tgt = '0;
            if (i_cfg.miss_en) rt.kind = sti1d_pkg::KIND_MISS;
        end else if (ip >= nn) begin
            tgt = nm1;
            if (i_cfg.miss_en) rt.kind = sti1d_pkg::KIND_MISS;
        end else if (mode_eff == sti1d_pkg::MODE_LINEAR) begin
            rt.wsel = sti1d_pkg::WSEL_LINEAR;
            tgt     = ip;
        end else if (ip >= nm1) begin
            tgt = nm1;
        end else begin
            rt.wsel = sti1d_pkg::WSEL_CUBIC;
            tgt     = ip;
        end

        rt.a0 = tgt[15:0];
        rt.a1 = tgt[15:0];
        rt.a2 = tgt[15:0];
        rt.a3 = tgt[15:0];
        if (rt.wsel == sti1d_pkg::WSEL_LINEAR) begin
            rt.a2 = (ip < nm1) ? ip_p1[15:0] : nm1[15:0];
            rt.a3 = rt.a2;
        end else if (rt.wsel == sti1d_pkg::WSEL_CUBIC) begin
            rt.a0 = (ip == '0) ? 16'd0 : 16'(ip - 18'sd1);
            rt.a2 = ip_p1[15:0];
            rt.a3 = (ip_p2 > nm1) ? nm1[15:0] : ip_p2[15:0];
        end

        // fraction cut to 15 bits for the kernel
        u_c = i_pos[sti1d_pkg::FRAC_BITS-1 -: 15];
        v_c = 16'(17'h08000 - {2'b0, u_c});
        g_c = (!i_cfg.gamma[15] && i_cfg.gamma != '0) ? -16'sd32768 : i_cfg.gamma;
    end

    // pipeline registers
    logic              r_f1_v, r_f2_v, r_f3_v, r_f4_v;
    sti1d_pkg::t_route r_f1_rt, r_f2_rt, r_f3_rt, r_f4_rt;
    logic [14:0]       r_f1_u, r_f2_u, r_f3_u;
    logic [15:0]       r_f1_v16, r_f2_v16, r_f3_v16;
    logic signed [15:0] r_f1_g, r_f2_g;
    logic signed [17:0] r_f1_gp2, r_f1_gp3, r_f2_gp2, r_f2_gp3, r_f3_gp2, r_f3_gp3;
    logic [29:0]       r_f2_uu, r_f3_uu;
    logic [30:0]       r_f2_uv, r_f2_vv, r_f3_vv;
    logic signed [47:0] r_f3_t0;
    logic [44:0]       r_f3_u3;
    logic [46:0]       r_f3_v3;
    logic signed [63:0] r_f4_t0v, r_f4_t0u, r_f4_a1, r_f4_b1, r_f4_a2, r_f4_b2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
            r_f3_v <= 1'b0;
            r_f4_v <= 1'b0;
        end else if (adv) begin
            r_f1_v <= i_valid;
            r_f2_v <= r_f1_v;
            r_f3_v <= r_f2_v;
            r_f4_v <= r_f3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f1_rt  <= rt;
            r_f1_u   <= u_c;
            r_f1_v16 <= v_c;
            r_f1_g   <= g_c;
            r_f1_gp2 <= 18'(g_c) + 18'sd65536;
            r_f1_gp3 <= 18'(g_c) + 18'sd98304;

            r_f2_rt  <= r_f1_rt;
            r_f2_u   <= r_f1_u;
            r_f2_v16 <= r_f1_v16;
            r_f2_g   <= r_f1_g;
            r_f2_gp2 <= r_f1_gp2;
            r_f2_gp3 <= r_f1_gp3;
            r_f2_uu  <= r_f1_u * r_f1_u;
            r_f2_uv  <= r_f1_u * r_f1_v16;
            r_f2_vv  <= r_f1_v16 * r_f1_v16;

            r_f3_rt  <= r_f2_rt;
            r_f3_u   <= r_f2_u;
            r_f3_v16 <= r_f2_v16;
            r_f3_gp2 <= r_f2_gp2;
            r_f3_gp3 <= r_f2_gp3;
            r_f3_uu  <= r_f2_uu;
            r_f3_vv  <= r_f2_vv;
            r_f3_t0  <= r_f2_g * $signed({1'b0, r_f2_uv});
            r_f3_u3  <= r_f2_uu * r_f2_u;
            r_f3_v3  <= r_f2_vv * r_f2_v16;

            r_f4_rt  <= r_f3_rt;
            r_f4_t0v <= r_f3_t0 * $signed({1'b0, r_f3_v16});
            r_f4_t0u <= r_f3_t0 * $signed({1'b0, r_f3_u});
            r_f4_a1  <= r_f3_gp2 * $signed({1'b0, r_f3_u3});
            r_f4_b1  <= r_f3_gp3 * $signed({1'b0, r_f3_uu});
            r_f4_a2  <= r_f3_gp2 * $signed({1'b0, r_f3_v3});
            r_f4_b2  <= r_f3_gp3 * $signed({1'b0, r_f3_vv});
        end
    end

    // weights in q30, rounded half up
    localparam logic signed [63:0] HALF = 64'sd1 <<< 29;
    localparam logic signed [63:0] ONE60 = 64'sd1 <<< 60;
    localparam logic signed [sti1d_pkg::W_BITS-1:0] W_ONE = 34'sd1 <<< 30;

    logic signed [63:0] s_w0, s_w1, s_w2, s_w3;
    logic [16:0]        frac_c;

    always_comb begin
        s_w0   = (r_f4_t0v + HALF) >>> 30;
        s_w3   = (r_f4_t0u + HALF) >>> 30;
        s_w1   = (r_f4_a1 - (r_f4_b1 <<< 15) + ONE60 + HALF) >>> 30;
        s_w2   = (r_f4_a2 - (r_f4_b2 <<< 15) + ONE60 + HALF) >>> 30;
        frac_c = 17'h10000 - {1'b0, r_f4_rt.frac};

        o_work.kind      = r_f4_rt.kind;
        o_work.tlast     = r_f4_rt.tlast;
        o_work.load_ok   = r_f4_rt.load_ok;
        o_work.load_data = r_f4_rt.load_data;
        o_work.a0        = r_f4_rt.a0;
        o_work.a1        = r_f4_rt.a1;
        o_work.a2        = r_f4_rt.a2;
        o_work.a3        = r_f4_rt.a3;
        o_work.w0        = '0;
        o_work.w1        = W_ONE;
        o_work.w2        = '0;
        o_work.w3        = '0;
        case (r_f4_rt.wsel)
            sti1d_pkg::WSEL_LINEAR: begin
                o_work.w1 = $signed({3'b0, frac_c, 14'b0});
                o_work.w2 = $signed({4'b0, r_f4_rt.frac, 14'b0});
            end
            sti1d_pkg::WSEL_CUBIC: begin
                o_work.w0 = s_w0[sti1d_pkg::W_BITS-1:0];
                o_work.w1 = s_w1[sti1d_pkg::W_BITS-1:0];
                o_work.w2 = s_w2[sti1d_pkg::W_BITS-1:0];
                o_work.w3 = s_w3[sti1d_pkg::W_BITS-1:0];
            end
            default: begin
                o_work.w1 = W_ONE;
            end
        endcase
    end

    assign o_push = r_f4_v && adv;
endmodule

@@ src/sti1d_queue.sv @@
// short fifo between front and back end
module sti1d_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sti1d_pkg::t_work i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output sti1d_pkg::t_work o_data
);
    localparam int PW = $clog2(sti1d_pkg::QUEUE_DEPTH);

    sti1d_pkg::t_work r_mem [sti1d_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [PW:0]      r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {{PW{1'b0}}, i_push} - {{PW{1'b0}}, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_full  = (r_cnt == (PW+1)'(sti1d_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(sti1d_pkg::QUEUE_DEPTH))
        else $error("queue count past depth");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != '0)
        else $error("pop from empty queue");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |-> !o_full)
        else $error("push into full queue");
endmodule

@@ src/sti1d_back.sv @@
// back end: banked table reads, weighted sum, rounding and saturation
module sti1d_back #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  sti1d_pkg::t_cfg                       i_cfg,
    input  logic                                  i_q_valid,
    input  sti1d_pkg::t_work                      i_work,
    output logic                                  o_pop,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [sti1d_pkg::SAMPLE_BITS-1:0] o_value,
    output logic                                  o_sat,
    output logic                                  o_last
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SB = sti1d_pkg::SAMPLE_BITS;
    localparam int PB = sti1d_pkg::W_BITS + SB;
    localparam int AB = PB + 2;
    localparam int QB = AB - 30;

    logic adv, wr;
    logic [SB-1:0] s0, s1, s2, s3;

    assign adv   = !o_valid || i_ready;
    assign o_pop = i_q_valid && adv;
    assign wr    = o_pop && i_work.kind == sti1d_pkg::KIND_LOAD && i_work.load_ok;

    // four copies of the table, one per kernel tap
    sti1d_ram #(.WIDTH(SB), .DEPTH(TABLE_DEPTH)) u_bank0 (
        .i_clk(i_clk), .i_we(wr), .i_waddr(i_work.a1[AW-1:0]), .i_wdata(i_work.load_data),
        .i_re(adv), .i_raddr(i_work.a0[AW-1:0]), .o_rdata(s0));
    sti1d_ram #(.WIDTH(SB), .DEPTH(TABLE_DEPTH)) u_bank1 (
        .i_clk(i_clk), .i_we(wr), .i_waddr(i_work.a1[AW-1:0]), .i_wdata(i_work.load_data),
        .i_re(adv), .i_raddr(i_work.a1[AW-1:0]), .o_rdata(s1));
    sti1d_ram #(.WIDTH(SB), .DEPTH(TABLE_DEPTH)) u_bank2 (
        .i_clk(i_clk), .i_we(wr), .i_waddr(i_work.a1[AW-1:0]), .i_wdata(i_work.load_data),
        .i_re(adv), .i_raddr(i_work.a2[AW-1:0]), .o_rdata(s2));
    sti1d_ram #(.WIDTH(SB), .DEPTH(TABLE_DEPTH)) u_bank3 (
        .i_clk(i_clk), .i_we(wr), .i_waddr(i_work.a1[AW-1:0]), .i_wdata(i_work.load_data),
        .i_re(adv), .i_raddr(i_work.a3[AW-1:0]), .o_rdata(s3));

    logic r_b1_v, r_b2_v, r_b3_v, r_out_v;
    logic r_b1_miss, r_b2_miss, r_b3_miss;
    logic r_b1_last, r_b2_last, r_b3_last;
    logic signed [sti1d_pkg::W_BITS-1:0] r_b1_w0, r_b1_w1, r_b1_w2, r_b1_w3;
    logic signed [PB-1:0] r_b2_p0, r_b2_p1, r_b2_p2, r_b2_p3;
    logic signed [AB-1:0] r_b3_acc;
    logic signed [SB-1:0] r_out_val;
    logic                 r_out_sat, r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v  <= 1'b0;
            r_b2_v  <= 1'b0;
            r_b3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_b1_v  <= o_pop && i_work.kind != sti1d_pkg::KIND_LOAD;
            r_b2_v  <= r_b1_v;
            r_b3_v  <= r_b2_v;
            r_out_v <= r_b3_v;
        end
    end

    // truncate toward zero, then clamp
    logic signed [AB-1:0] biased;
    logic signed [QB-1:0] q;
    logic                 hi, lo;
    localparam logic signed [AB-1:0] BIAS = (AB'(1) <<< 30) - AB'(1);
    localparam logic signed [QB-1:0] SMAX = QB'((64'sd1 <<< (SB-1)) - 64'sd1);
    localparam logic signed [QB-1:0] SMIN = -SMAX - QB'(1);

    always_comb begin
        biased = r_b3_acc + (r_b3_acc[AB-1] ? BIAS : '0);
        q      = biased[AB-1:30];
        hi     = q > SMAX;
        lo     = q < SMIN;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b1_miss <= i_work.kind == sti1d_pkg::KIND_MISS;
            r_b1_last <= i_work.tlast;
            r_b1_w0   <= i_work.w0;
            r_b1_w1   <= i_work.w1;
            r_b1_w2   <= i_work.w2;
            r_b1_w3   <= i_work.w3;

            r_b2_miss <= r_b1_miss;
            r_b2_last <= r_b1_last;
            r_b2_p0   <= r_b1_w0 * $signed(s0);
            r_b2_p1   <= r_b1_w1 * $signed(s1);
            r_b2_p2   <= r_b1_w2 * $signed(s2);
            r_b2_p3   <= r_b1_w3 * $signed(s3);

            r_b3_miss <= r_b2_miss;
            r_b3_last <= r_b2_last;
            r_b3_acc  <= AB'(r_b2_p0) + AB'(r_b2_p1) + AB'(r_b2_p2) + AB'(r_b2_p3);

            r_out_last <= r_b3_last;
            if (r_b3_miss) begin
                r_out_val <= SB'(i_cfg.miss_val);
                r_out_sat <= 1'b0;
            end else begin
                r_out_val <= hi ? SMAX[SB-1:0] : lo ? SMIN[SB-1:0] : q[SB-1:0];
                r_out_sat <= hi || lo;
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_value = r_out_val;
    assign o_sat   = r_out_sat;
    assign o_last  = r_out_last;
endmodule

@@ src/sample_table_interpolator_1d.sv @@
// top level of the one-dimensional sample table interpolator
//
// keeps a table of TABLE_DEPTH signed 16-bit samples and answers fractional
// position queries (signed q15.16) in nearest, linear or cubic convolution mode
// with a programmable kernel gamma. a beat with tuser 0 loads one sample and
// returns nothing; a beat with tuser 1 is a query and returns one beat. the block
// takes one beat per clock while the queue has room and returns results in order:
// a four-stage front end classifies the position and builds the four kernel
// weights, a four-entry queue lets front and back stall independently, and the
// back end reads four table copies in parallel, sums the weighted taps and
// saturates. a result beat passes in turn through the front registers, the queue,
// the table read and the product, sum and output registers; the pipelined
// multipliers and per-tap table copies let new beats enter before old ones finish.
// the table needs no clearing after reset, but a query must only touch entries
// already loaded. configuration is written through a plain write port while the
// block is idle.
module sample_table_interpolator_1d #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // sample_index [9:0], sample_value [25:10], position [57:26]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    // cmd [0]
    input  logic [0:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    // value [15:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,
    // saturated [0]
    output logic [0:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [sti1d_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [sti1d_pkg::CFG_BITS-1:0]     i_cfg_data
);
    sti1d_pkg::t_cfg  r_cfg;
    sti1d_pkg::t_work front_work, q_work;
    logic             push, q_full, q_valid, pop;
    logic signed [sti1d_pkg::SAMPLE_BITS-1:0] out_val;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode     <= sti1d_pkg::MODE_LINEAR;
            r_cfg.count    <= 11'd1024;
            r_cfg.gamma    <= -16'sd32768;
            r_cfg.miss_en  <= 1'b0;
            r_cfg.miss_val <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sti1d_pkg::CFG_MODE:     r_cfg.mode     <= i_cfg_data[1:0];
                sti1d_pkg::CFG_COUNT:    r_cfg.count    <= i_cfg_data[sti1d_pkg::CNT_BITS-1:0];
                sti1d_pkg::CFG_GAMMA:    r_cfg.gamma    <= i_cfg_data;
                sti1d_pkg::CFG_MISS_EN:  r_cfg.miss_en  <= i_cfg_data[0];
                sti1d_pkg::CFG_MISS_VAL: r_cfg.miss_val <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // front end: classify and build weights
    sti1d_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_cmd    (s_axis_tuser[0]),
        .i_idx    (s_axis_tdata[9:0]),
        .i_sample (s_axis_tdata[25:10]),
        .i_pos    (s_axis_tdata[57:26]),
        .i_last   (s_axis_tlast),
        .i_q_full (q_full),
        .o_push   (push),
        .o_work   (front_work)
    );

    // decoupling queue
    sti1d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_work),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_work)
    );

    // back end: table reads and kernel sum
    sti1d_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_work    (q_work),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_value   (out_val),
        .o_sat     (m_axis_tuser[0]),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = out_val;
endmodule

@@ tb/sti1d_checker.sv @@
// checker for the interpolator: mirrors config and table, predicts each query result and compares
`timescale 1ns / 1ps
module sti1d_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic [63:0]                        i_in_data,
    input  logic [0:0]                         i_in_user,
    input  logic                               i_in_last,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic [15:0]                        i_out_data,
    input  logic [0:0]                         i_out_user,
    input  logic                               i_out_last,
    input  logic                               i_cfg_we,
    input  logic [sti1d_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [sti1d_pkg::CFG_BITS-1:0]     i_cfg_data,
    output int                                 o_errors,
    output int                                 o_pending
);

    localparam int DEPTH = 1024;

    typedef struct {
        logic signed [15:0] value;
        logic               sat;
        logic               last;
    } t_answer;

    logic [1:0]                     mode_q;
    logic [sti1d_pkg::CNT_BITS-1:0] count_q;
    logic signed [15:0]             gamma_q;
    logic                           miss_en_q;
    logic signed [15:0]             miss_val_q;
    logic signed [15:0]             samples[DEPTH];
    t_answer                        answers_due[$];
    int                             errors;

    assign o_errors  = errors;
    assign o_pending = answers_due.size();

    function automatic longint tap(longint i, longint n);
        if (i < 0) i = 0;
        if (i > n - 1) i = n - 1;
        return longint'(samples[i]);
    endfunction

    // centre weight of the cubic kernel, q60 rounded to q30
    function automatic longint centre_weight(longint g, longint u);
        longint one;
        longint c;
        one = longint'(1) << 15;
        c = (g + 2 * one) * u * u * u - (g + 3 * one) * u * u * one + (longint'(1) << 60);
        return (c + (longint'(1) << 29)) >>> 30;
    endfunction

    function automatic t_answer interpolate(logic signed [31:0] pos, logic last);
        t_answer a;
        longint  n, p, ip, frac, val, g, u, v, w0, w1, w2, w3, acc, one;
        logic [1:0] md;
        one = longint'(1) << 15;
        n = count_q;
        if (n < 1) n = 1;
        if (n > DEPTH) n = DEPTH;
        // the spare mode code behaves as linear
        md = (mode_q == sti1d_pkg::MODE_NEAREST || mode_q == sti1d_pkg::MODE_CUBIC)
           ? mode_q : sti1d_pkg::MODE_LINEAR;
        if (md == sti1d_pkg::MODE_CUBIC && n < 3) md = sti1d_pkg::MODE_LINEAR;
        if (n < 2) md = sti1d_pkg::MODE_NEAREST;
        p    = longint'(pos);
        ip   = p >>> sti1d_pkg::FRAC_BITS;
        frac = p & 64'hFFFF;
        a.sat  = 1'b0;
        a.last = last;
        if (md == sti1d_pkg::MODE_NEAREST) begin
            if (p < 0) val = tap(0, n);
            else if (p < ((n - 1) <<< sti1d_pkg::FRAC_BITS)) val = tap(ip, n);
            else val = tap(n - 1, n);
        end else if (p < 0) begin
            val = miss_en_q ? longint'(miss_val_q) : tap(0, n);
        end else if (p >= (n <<< sti1d_pkg::FRAC_BITS)) begin
            val = miss_en_q ? longint'(miss_val_q) : tap(n - 1, n);
        end else if (md == sti1d_pkg::MODE_LINEAR) begin
            acc = tap(ip, n) * 65536 + frac * (tap(ip + 1, n) - tap(ip, n));
            val = acc / 65536;
        end else if (p >= ((n - 1) <<< sti1d_pkg::FRAC_BITS)) begin
            val = tap(n - 1, n);
        end else begin
            g = longint'(gamma_q);
            if (g > 0) g = -one;
            u  = frac >> (sti1d_pkg::FRAC_BITS - 15);
            v  = one - u;
            w0 = (g * u * v * v + (longint'(1) << 29)) >>> 30;
            w3 = (g * u * u * v + (longint'(1) << 29)) >>> 30;
            w1 = centre_weight(g, u);
            w2 = centre_weight(g, v);
            acc = w0 * tap(ip - 1, n) + w1 * tap(ip, n) + w2 * tap(ip + 1, n)
                + w3 * tap(ip + 2, n);
            val = acc / (longint'(1) << 30);
            if (val > 32767) begin
                val = 32767;
                a.sat = 1'b1;
            end
            if (val < -32768) begin
                val = -32768;
                a.sat = 1'b1;
            end
        end
        a.value = val[15:0];
        return a;
    endfunction

    task automatic report(string what, int got, int want);
        $display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    always_ff @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            mode_q     <= sti1d_pkg::MODE_LINEAR;
            count_q    <= 11'd1024;
            gamma_q    <= -16'sd32768;
            miss_en_q  <= 1'b0;
            miss_val_q <= '0;
            answers_due.delete();
            errors = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sti1d_pkg::CFG_MODE:     mode_q     <= i_cfg_data[1:0];
                    sti1d_pkg::CFG_COUNT:    count_q    <= i_cfg_data[sti1d_pkg::CNT_BITS-1:0];
                    sti1d_pkg::CFG_GAMMA:    gamma_q    <= i_cfg_data;
                    sti1d_pkg::CFG_MISS_EN:  miss_en_q  <= i_cfg_data[0];
                    sti1d_pkg::CFG_MISS_VAL: miss_val_q <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_user[0]) answers_due.push_back(interpolate(i_in_data[57:26], i_in_last));
                else samples[i_in_data[9:0]] = i_in_data[25:10];
            end
            if (i_out_valid && i_out_ready) begin
                if (answers_due.size() == 0) begin
                    $display("%0t ns: result beat with nothing expected", $time);
                    errors++;
                end else begin
                    want = answers_due.pop_front();
                    if (i_out_data !== want.value)
                        report("value", $signed(i_out_data), want.value);
                    if (i_out_user[0] !== want.sat) report("saturated", i_out_user[0], want.sat);
                    if (i_out_last !== want.last) report("batch end", i_out_last, want.last);
                end
            end
        end
    end

endmodule

@@ tb/sample_table_interpolator_1d_tb.sv @@
// testbench top: stimulus, config phases and verdict for the 1-d sample table interpolator
`timescale 1ns / 1ps
module sample_table_interpolator_1d_tb;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [63:0]                        s_axis_tdata;
    logic [0:0]                         s_axis_tuser;
    logic                               s_axis_tlast;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    logic [15:0]                        m_axis_tdata;
    logic [0:0]                         m_axis_tuser;
    logic                               m_axis_tlast;
    logic                               i_cfg_we;
    logic [sti1d_pkg::CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [sti1d_pkg::CFG_BITS-1:0]     i_cfg_data;
    int                                 errors;
    int                                 pending;

    // table slots loaded so far; a query may only reach loaded slots
    bit  loaded[1024];
    // when set, neither side idles (back-to-back stretches)
    bit  calm;
    int  table_size;

    sample_table_interpolator_1d dut (.*);

    sti1d_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_in_last   (s_axis_tlast),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_user  (m_axis_tuser),
        .i_out_last  (m_axis_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // hard stop in case a handshake hangs
    initial begin
        #2000000;
        $display("sample_table_interpolator_1d_tb: done, errors");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        if (calm) return 0;
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // result side: ready toggles with random hold times, one change per falling edge
    initial begin
        int hold;
        hold = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (!m_axis_tready) begin
                m_axis_tready <= 1'b1;
                hold = $urandom_range(0, 20);
            end else begin
                hold = idle_len();
                if (hold > 0) begin
                    m_axis_tready <= 1'b0;
                    hold--;
                end
            end
        end
    end

    // one beat on the input channel; called at a falling edge
    task automatic send_beat(bit is_query, logic [9:0] idx, logic [15:0] sample,
                             logic [31:0] pos, bit last);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= {6'b0, pos, sample, idx};
        s_axis_tuser  <= is_query;
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        if (!is_query) loaded[idx] = 1'b1;
    endtask

    task automatic load(logic [9:0] idx, logic [15:0] sample);
        send_beat(1'b0, idx, sample, $urandom, 1'($urandom_range(0, 1)));
    endtask

    task automatic query(logic [31:0] pos);
        send_beat(1'b1, 10'($urandom), 16'($urandom), pos, 1'($urandom_range(0, 1)));
    endtask

    // config write, only with the block idle
    task automatic write_reg(logic [sti1d_pkg::CFG_IDX_BITS-1:0] idx,
                             logic [sti1d_pkg::CFG_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == sti1d_pkg::CFG_COUNT) begin
            table_size = int'(data[sti1d_pkg::CNT_BITS-1:0]);
            if (table_size < 1) table_size = 1;
            if (table_size > 1024) table_size = 1024;
        end
    endtask

    // drop valid, wait for every result, then cover loads still in flight
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (20) @(negedge i_clk);
    endtask

    // loads every slot the current table size can reach that is not loaded yet
    task automatic fill_table();
        for (int k = 0; k < table_size; k++)
            if (!loaded[k]) load(10'(k), 16'($urandom));
    endtask

    function automatic logic [15:0] random_sample();
        case ($urandom_range(0, 3))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] random_position();
        int n;
        n = table_size;
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return {16'($urandom_range(0, n - 1)), 16'h0};
            2: return 32'(n - 1) << 16 | $urandom_range(0, 16'hFFFF);
            3: return 32'(n) << 16 | $urandom_range(0, 3);
            4: return -32'($urandom_range(1, 70000));
            default: return (32'($urandom_range(0, n)) << 16) | $urandom_range(0, 16'hFFFF);
        endcase
    endfunction

    initial begin
        int counts[12] = '{1, 2, 3, 4, 5, 16, 64, 0, 200, 1024, 2047, 3};
        logic [15:0] gam;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = sti1d_pkg::CFG_MODE;
        i_cfg_data    = '0;
        calm          = 1'b0;
        table_size    = 1024;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: cubic on a table of full-scale alternating samples
        write_reg(sti1d_pkg::CFG_COUNT, 16'd16);
        write_reg(sti1d_pkg::CFG_MODE, 16'(sti1d_pkg::MODE_CUBIC));
        for (int k = 0; k < 16; k++) load(10'(k), k[0] ? 16'h8000 : 16'h7FFF);
        load(10'd1023, 16'h0);
        query(32'h0000_8000);           // cubic, first tap clamped to slot 0
        query(32'h0001_8000);
        query(32'h0000_0000);
        query(32'h000F_0000);           // last sample exactly
        query(32'h000F_FFFF);           // between last and end
        query(32'h0010_0000);           // past the end
        query(32'h7FFF_FFFF);
        query(32'h8000_0000);
        query(32'hFFFF_FFFF);           // just below zero
        drain();
        write_reg(sti1d_pkg::CFG_MISS_EN, 16'd1);
        write_reg(sti1d_pkg::CFG_MISS_VAL, 16'h8000);
        write_reg(sti1d_pkg::CFG_GAMMA, 16'h0000);
        query(32'hFFFF_FFFF);
        query(32'h0010_0000);
        query(32'h0007_4000);
        drain();
        write_reg(sti1d_pkg::CFG_MODE, 16'(sti1d_pkg::MODE_LINEAR));
        query(32'h0003_C000);
        query(32'h000F_8000);           // clamps to the last neighbour
        drain();
        write_reg(sti1d_pkg::CFG_MODE, 16'(sti1d_pkg::MODE_NEAREST));
        query(32'h0002_FFFF);
        query(32'h0010_0000);           // missing mode has no effect here
        query(32'h8000_0000);
        drain();

        // random phases over a range of settings, extremes included
        for (int ph = 0; ph < 12; ph++) begin
            case ($urandom_range(0, 3))
                0: gam = 16'h8000;
                1: gam = 16'h0000;
                2: gam = 16'h7FFF;       // positive, acts as -1.0
                default: gam = -16'($urandom_range(0, 32768));
            endcase
            write_reg(sti1d_pkg::CFG_MODE, (ph % 4 == 3) ? 16'(sti1d_pkg::MODE_SPARE)
                                                         : 16'($urandom_range(0, 2)));
            write_reg(sti1d_pkg::CFG_COUNT, 16'(counts[ph]));
            write_reg(sti1d_pkg::CFG_GAMMA, gam);
            write_reg(sti1d_pkg::CFG_MISS_EN, 16'($urandom_range(0, 1)));
            write_reg(sti1d_pkg::CFG_MISS_VAL, 16'($urandom));
            calm = (ph % 3 == 1);
            fill_table();
            repeat (35) begin
                if ($urandom_range(0, 3) == 0) load(10'($urandom_range(0, 1023)), random_sample());
                else query(random_position());
            end
            drain();
        end

        if (errors == 0) begin
            $display("sample_table_interpolator_1d_tb: done, clean");
        end else begin
            $display("sample_table_interpolator_1d_tb: done, errors");
        end
        $finish;
    end

endmodule
